/* hw/rtl/utf8_to_utf16_bmp_decoder_assert.svh */
// ----------------------------------------------------------------------------
// UTF-8 to UTF-16 decoder assertion macros
// Short forms for the concurrent checks used by the decoder checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF16_BMP_DECODER_ASSERT_SVH
`define UTF8_TO_UTF16_BMP_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high
`define U8U16_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("u8u16 check failed");

// Next-cycle implication, disabled while reset is high
`define U8U16_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("u8u16 check failed");

`endif

/* hw/rtl/u8u16_pkg.sv */
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants of the UTF-8 to UTF-16 (BMP) decoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

   // Result status codes
   localparam logic [2:0] ST_CHAR     = 3'd0;
   localparam logic [2:0] ST_END      = 3'd1;
   localparam logic [2:0] ST_FOUR     = 3'd2;
   localparam logic [2:0] ST_STRAY    = 3'd3;
   localparam logic [2:0] ST_BADCONT  = 3'd4;
   localparam logic [2:0] ST_OVERFLOW = 3'd5;

   // Top two bits of a continuation byte
   localparam logic [1:0] CONT_TAG = 2'b10;

   // Capacity after reset
   localparam logic [15:0] CAP_RESET = 16'hFFFF;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // One result item
   typedef struct packed {
      logic [15:0] code_unit;
      logic [2:0]  status;
   } item_type;

   // Queue status seen by the front and back
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

/* hw/rtl/utf8_to_utf16_bmp_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_to_utf16_bmp_decoder
// Decodes a zero-terminated UTF-8 byte stream into UTF-16 BMP code units.
// ----------------------------------------------------------------------------
// Channel   Dir  Signals                       Content
// req       in   req_tvalid/tready/tdata[7:0]  one UTF-8 byte
// rsp       out  rsp_tvalid/tready/tdata[15:0] code unit, tuser[2:0] status
// csr       in   csr_wen, csr_wdata[15:0]      output capacity
//
// One byte is accepted per cycle; the decode front finishes each byte in the
// cycle it is accepted. Each result goes via the queue and output register.
// A four-entry queue and the output register decouple the two sides: req
// stalls only when the queue is full. Reset is synchronous and clears the
// string state, the queue and the output, and sets capacity to 65535.
// ----------------------------------------------------------------------------
module utf8_to_utf16_bmp_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] code_unit
   output logic [2:0]  rsp_tuser,   // [2:0] status
   input  logic        csr_wen,
   input  logic [15:0] csr_wdata
);

   u8u16_pkg::qstat_type qstat;
   u8u16_pkg::item_type  push_item;
   u8u16_pkg::item_type  pop_item;
   logic                 push;
   logic                 pop;

   u8u16_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .qstat      (qstat),
      .push       (push),
      .push_item  (push_item)
   );

   u8u16_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .qstat     (qstat)
   );

   u8u16_back u_back (
      .clock      (clock),
      .reset      (reset),
      .qstat      (qstat),
      .pop_item   (pop_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* hw/rtl/u8u16_queue.sv */
// ----------------------------------------------------------------------------
// u8u16_queue
// Short FIFO of result items between the decode front and the output back.
// ----------------------------------------------------------------------------
module u8u16_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  u8u16_pkg::item_type push_item,
   input  logic                pop,
   output u8u16_pkg::item_type pop_item,
   output u8u16_pkg::qstat_type qstat
);

   u8u16_pkg::item_type              slot_ff [u8u16_pkg::QUEUE_DEPTH];
   logic [u8u16_pkg::QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [u8u16_pkg::QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [u8u16_pkg::QUEUE_AW:0]     count_ff, count_in;

   // Status and head of queue
   assign qstat.full  = (count_ff == (u8u16_pkg::QUEUE_AW+1)'(u8u16_pkg::QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign pop_item    = slot_ff[rd_ptr_ff];

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* hw/rtl/u8u16_front.sv */
// ----------------------------------------------------------------------------
// u8u16_front
// Accepts UTF-8 bytes, classifies them, tracks the running character and
// the unit count, and pushes a result item when one is due.
// ----------------------------------------------------------------------------
module u8u16_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,
   input  logic                 csr_wen,
   input  logic [15:0]          csr_wdata,
   input  u8u16_pkg::qstat_type qstat,
   output logic                 push,
   output u8u16_pkg::item_type  push_item
);

   logic [15:0] cap_ff;
   logic [1:0]  pend_ff, pend_in;
   logic [15:0] part_ff, part_in;
   logic [15:0] written_ff, written_in;

   logic        accept;
   logic        do_complete;
   logic [15:0] unit;
   logic        do_fail;
   logic [2:0]  fail_code;

   assign req_tready = !qstat.full;
   assign accept     = req_tvalid && req_tready;

   // Classify byte and update running state
   always_comb begin
      pend_in     = pend_ff;
      part_in     = part_ff;
      written_in  = written_ff;
      push        = 1'b0;
      push_item   = '{code_unit: 16'h0000, status: u8u16_pkg::ST_CHAR};
      do_complete = 1'b0;
      unit        = 16'h0000;
      do_fail     = 1'b0;
      fail_code   = u8u16_pkg::ST_CHAR;

      if (accept) begin
         if (pend_ff != 2'd0) begin
            if (req_tdata[7:6] != u8u16_pkg::CONT_TAG) begin
               do_fail   = 1'b1;
               fail_code = u8u16_pkg::ST_BADCONT;
            end else if (pend_ff == 2'd2) begin
               part_in = part_ff | {4'b0000, req_tdata[5:0], 6'b000000};
               pend_in = 2'd1;
            end else begin
               unit        = part_ff | {10'b0, req_tdata[5:0]};
               pend_in     = 2'd0;
               part_in     = 16'h0000;
               do_complete = 1'b1;
            end
         end else if (!req_tdata[7]) begin
            unit        = {8'h00, req_tdata};
            do_complete = 1'b1;
         end else if (!req_tdata[6]) begin
            do_fail   = 1'b1;
            fail_code = u8u16_pkg::ST_STRAY;
         end else if (!req_tdata[5]) begin
            part_in = {5'b00000, req_tdata[4:0], 6'b000000};
            pend_in = 2'd1;
         end else if (!req_tdata[4]) begin
            part_in = {req_tdata[3:0], 12'h000};
            pend_in = 2'd2;
         end else begin
            do_fail   = 1'b1;
            fail_code = u8u16_pkg::ST_FOUR;
         end
      end

      // Capacity check on a completed character
      if (do_complete) begin
         if (written_ff >= cap_ff) begin
            do_fail   = 1'b1;
            fail_code = u8u16_pkg::ST_OVERFLOW;
         end else if (unit == 16'h0000) begin
            pend_in    = 2'd0;
            part_in    = 16'h0000;
            written_in = 16'h0000;
            push       = 1'b1;
            push_item  = '{code_unit: 16'h0000, status: u8u16_pkg::ST_END};
         end else begin
            written_in = written_ff + 16'd1;
            push       = 1'b1;
            push_item  = '{code_unit: unit, status: u8u16_pkg::ST_CHAR};
         end
      end

      // Drop the string on an error
      if (do_fail) begin
         pend_in    = 2'd0;
         part_in    = 16'h0000;
         written_in = 16'h0000;
         push       = 1'b1;
         push_item  = '{code_unit: 16'h0000, status: fail_code};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff     <= u8u16_pkg::CAP_RESET;
         pend_ff    <= 2'd0;
         part_ff    <= 16'h0000;
         written_ff <= 16'h0000;
      end else begin
         if (csr_wen) begin
            cap_ff <= csr_wdata;
         end
         pend_ff    <= pend_in;
         part_ff    <= part_in;
         written_ff <= written_in;
      end
   end

endmodule

/* hw/rtl/u8u16_back.sv */
// ----------------------------------------------------------------------------
// u8u16_back
// Pops result items from the queue into the output register and hands them
// to the result channel.
// ----------------------------------------------------------------------------
module u8u16_back (
   input  logic                 clock,
   input  logic                 reset,
   input  u8u16_pkg::qstat_type qstat,
   input  u8u16_pkg::item_type  pop_item,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,
   output logic [2:0]           rsp_tuser
);

   logic                valid_ff, valid_in;
   u8u16_pkg::item_type item_ff;

   // Refill when the register is empty or being taken
   assign pop      = !qstat.empty && (!valid_ff || rsp_tready);
   assign valid_in = pop || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= pop_item;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = item_ff.code_unit;
   assign rsp_tuser  = item_ff.status;

endmodule

/* hw/rtl/u8u16_checker.sv */
// ----------------------------------------------------------------------------
// u8u16_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "utf8_to_utf16_bmp_decoder_assert.svh"

module u8u16_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   logic        rsp_stall;
   logic        rsp_char;
   logic        rsp_other;
   logic [18:0] rsp_item;

   // Result channel views used by the checks
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_char  = rsp_tvalid && (rsp_tuser == u8u16_pkg::ST_CHAR);
   assign rsp_other = rsp_tvalid && (rsp_tuser != u8u16_pkg::ST_CHAR);
   assign rsp_item  = {rsp_tdata, rsp_tuser};

   // A stalled result holds
   `U8U16_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_item))

   // Status stays within the defined codes
   `U8U16_ASSERT_IMPLY(a_status_range, clock, reset, rsp_tvalid, rsp_tuser <= u8u16_pkg::ST_OVERFLOW)

   // End and error items carry a zero unit, characters a nonzero one
   `U8U16_ASSERT_IMPLY(a_zero_unit, clock, reset, rsp_other, rsp_tdata == 16'h0000)
   `U8U16_ASSERT_IMPLY(a_char_unit, clock, reset, rsp_char, rsp_tdata != 16'h0000)

   // Output is empty right after reset
   `U8U16_ASSERT_IMPLY(a_reset_empty, clock, reset, $fell(reset), !rsp_tvalid)

endmodule

bind utf8_to_utf16_bmp_decoder u8u16_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
